>>> hw/rtl/two_value_multimap_table_defines.svh
// Assertion macros shared by the two-value multimap table RTL.
// Each macro expects a clock named clk in the scope where it is used.
`ifndef TWO_VALUE_MULTIMAP_TABLE_DEFINES_SVH
`define TWO_VALUE_MULTIMAP_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while the reset is asserted.
`define TVMT_ASSERT_IMP(label, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while the reset is asserted.
`define TVMT_ASSERT_NEXT(label, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/tvmt_pkg.sv
// Shared types and constants of the two-value multimap table.
// No dependencies; used by tvmt_ctrl and the top level.
`default_nettype none

package tvmt_pkg;

	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int ENTRY_W     = KEY_W + VAL_W;
	localparam int CAP_W       = 5;
	localparam int COUNT_OUT_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [1:0]       FOUND_MAX = 2'd2;

	typedef enum logic [1:0] {
		CMD_ADD        = 2'd0,
		CMD_SEARCH     = 2'd1,
		CMD_REMOVE     = 2'd2,
		CMD_REMOVE_KEY = 2'd3
	} command_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		status_t                  status;
		logic [1:0]               found_count;
		logic signed [VAL_W-1:0]  first_value;
		logic signed [VAL_W-1:0]  second_value;
		logic [COUNT_OUT_W-1:0]   entry_count;
		logic                     table_empty;
		logic                     table_full;
	} result_t;

endpackage

`default_nettype wire

>>> hw/rtl/tvmt_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module tvmt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/tvmt_ctrl.sv
// Command sequencer of the two-value multimap table: scans the entry RAM,
// appends pairs and moves the last entry into freed slots. Uses tvmt_pkg.
`default_nettype none

module tvmt_ctrl #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	output logic                                         in_stall,
	input  wire logic [1:0]                              command,
	input  wire logic signed [tvmt_pkg::KEY_W-1:0]       key,
	input  wire logic signed [tvmt_pkg::VAL_W-1:0]       value,
	input  wire logic [$clog2(MAX_ENTRIES+1)-1:0]        cap_eff,
	output logic                                         ram_we,
	output logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] ram_waddr,
	output logic [tvmt_pkg::ENTRY_W-1:0]                 ram_wdata,
	output logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] ram_raddr,
	input  wire logic [tvmt_pkg::ENTRY_W-1:0]            ram_rdata,
	output logic                                         res_valid,
	input  wire logic                                    res_free,
	output tvmt_pkg::result_t                            res
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MOVE_RD,
		S_MOVE_WR,
		S_FIN
	} state_t;

	state_t                         state_q;
	tvmt_pkg::command_t             cmd_q;
	tvmt_pkg::status_t              status_q;
	logic [tvmt_pkg::KEY_W-1:0]     key_q;
	logic [tvmt_pkg::VAL_W-1:0]     val_q;
	logic [tvmt_pkg::VAL_W-1:0]     v1_q;
	logic [tvmt_pkg::VAL_W-1:0]     v2_q;
	logic [CNT_W-1:0]               count_q;
	logic [CNT_W-1:0]               ridx_q;
	logic                           pend_q;
	logic [IDX_W-1:0]               pidx_q;
	logic [IDX_W-1:0]               slot_q;
	logic [1:0]                     found_q;

	logic                           hit_key;
	logic                           hit_pair;
	logic                           match;
	logic                           scan_more;
	logic                           scan_done;
	logic                           add_commit;
	logic                           returns_values;
	logic [CNT_W-1:0]               last_cnt;

	// The read issued in one cycle returns its data in the next; pend_q marks
	// that the data on ram_rdata belongs to entry pidx_q of the scan.
	always_comb begin
		hit_key    = pend_q && (ram_rdata[tvmt_pkg::ENTRY_W-1:tvmt_pkg::VAL_W] == key_q);
		hit_pair   = hit_key && (ram_rdata[tvmt_pkg::VAL_W-1:0] == val_q);
		match      = (cmd_q == tvmt_pkg::CMD_REMOVE) ? hit_pair : hit_key;
		scan_more  = ridx_q < count_q;
		scan_done  = !pend_q && !scan_more;
		add_commit = (state_q == S_SCAN) && (cmd_q == tvmt_pkg::CMD_ADD) && scan_done;
		last_cnt   = count_q - CNT_W'(1);

		ram_we    = add_commit || (state_q == S_MOVE_WR);
		ram_waddr = (state_q == S_MOVE_WR) ? slot_q : count_q[IDX_W-1:0];
		ram_wdata = (state_q == S_MOVE_WR) ? ram_rdata : {key_q, val_q};
		ram_raddr = (state_q == S_MOVE_RD) ? last_cnt[IDX_W-1:0] : ridx_q[IDX_W-1:0];

		returns_values = (cmd_q == tvmt_pkg::CMD_SEARCH) ||
		                 (cmd_q == tvmt_pkg::CMD_REMOVE_KEY);

		in_stall  = (state_q != S_IDLE);
		res_valid = (state_q == S_FIN);

		res.status       = status_q;
		res.found_count  = returns_values ? found_q : 2'd0;
		res.first_value  = v1_q;
		res.second_value = v2_q;
		res.entry_count  = tvmt_pkg::COUNT_OUT_W'(count_q);
		res.table_empty  = (count_q == '0);
		res.table_full   = (count_q >= cap_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q    <= tvmt_pkg::command_t'(command);
						key_q    <= key;
						val_q    <= value;
						found_q  <= 2'd0;
						v1_q     <= '0;
						v2_q     <= '0;
						ridx_q   <= '0;
						pend_q   <= 1'b0;
						status_q <= tvmt_pkg::ST_MISS;
						if ((tvmt_pkg::command_t'(command) == tvmt_pkg::CMD_ADD) &&
						    (count_q >= cap_eff)) begin
							status_q <= tvmt_pkg::ST_FULL;
							state_q  <= S_FIN;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					pend_q <= scan_more;
					pidx_q <= ridx_q[IDX_W-1:0];
					if (scan_more) begin
						ridx_q <= ridx_q + CNT_W'(1);
					end
					if (match) begin
						case (cmd_q)
							tvmt_pkg::CMD_ADD: begin
								// A second stored value for this key rejects the add.
								if (found_q + 2'd1 == tvmt_pkg::FOUND_MAX) begin
									pend_q   <= 1'b0;
									status_q <= tvmt_pkg::ST_MISS;
									state_q  <= S_FIN;
								end else begin
									found_q <= found_q + 2'd1;
								end
							end
							tvmt_pkg::CMD_SEARCH: begin
								if (found_q == 2'd0) begin
									v1_q <= ram_rdata[tvmt_pkg::VAL_W-1:0];
								end else begin
									v2_q <= ram_rdata[tvmt_pkg::VAL_W-1:0];
								end
								found_q <= found_q + 2'd1;
								if (found_q + 2'd1 == tvmt_pkg::FOUND_MAX) begin
									pend_q   <= 1'b0;
									status_q <= tvmt_pkg::ST_OK;
									state_q  <= S_FIN;
								end
							end
							tvmt_pkg::CMD_REMOVE: begin
								pend_q   <= 1'b0;
								slot_q   <= pidx_q;
								status_q <= tvmt_pkg::ST_OK;
								state_q  <= S_MOVE_RD;
							end
							default: begin
								if (found_q == 2'd0) begin
									v1_q <= ram_rdata[tvmt_pkg::VAL_W-1:0];
								end else begin
									v2_q <= ram_rdata[tvmt_pkg::VAL_W-1:0];
								end
								found_q  <= found_q + 2'd1;
								pend_q   <= 1'b0;
								slot_q   <= pidx_q;
								status_q <= tvmt_pkg::ST_OK;
								state_q  <= S_MOVE_RD;
							end
						endcase
					end else if (scan_done) begin
						if (cmd_q == tvmt_pkg::CMD_ADD) begin
							count_q  <= count_q + CNT_W'(1);
							status_q <= tvmt_pkg::ST_OK;
						end else if (found_q != 2'd0) begin
							status_q <= tvmt_pkg::ST_OK;
						end
						state_q <= S_FIN;
					end
				end
				S_MOVE_RD: begin
					state_q <= S_MOVE_WR;
				end
				S_MOVE_WR: begin
					// The last entry lands in the freed slot; remove-key, until it has found
					// two values, then re-examines that slot before moving on.
					count_q <= last_cnt;
					if ((cmd_q == tvmt_pkg::CMD_REMOVE) || (found_q == tvmt_pkg::FOUND_MAX)) begin
						state_q <= S_FIN;
					end else begin
						ridx_q  <= CNT_W'(slot_q);
						pend_q  <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_FIN: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/two_value_multimap_table.sv
// Top level of the two-value multimap table: capacity register, entry RAM,
// sequencer and result register. Uses tvmt_pkg, tvmt_ram, tvmt_ctrl and the
// assertion macros of two_value_multimap_table_defines.svh.
//
// Usage: a request (command, key, value) is taken on the input channel when
// in_valid is high and in_stall is low; exactly one result leaves on the
// output channel when out_valid is high and out_stall is low. The user must
// write the capacity register with cfg_we and cfg_wdata only while the block
// is idle; the block itself does not enforce this. A request scans the held
// entries one per cycle through the RAM's single read port, pausing the scan
// for each deletion, which reads the last entry, writes it into the freed
// slot and may restart the scan there. An add to a full table skips the scan.
// The block works one request at a time and takes no new one until the
// result of the last has moved into the output register.
// Reset empties the table and sets the capacity to 16; the RAM contents are
// not cleared, since only entries below the count are ever read.
// When the receiver stalls, the result waits in the output register, the
// block still takes one more request and works it, then holds that result
// until the output register frees.
`default_nettype none

module two_value_multimap_table #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    cfg_we,
	input  wire logic [tvmt_pkg::CAP_W-1:0]              cfg_wdata,
	input  wire logic                                    in_valid,
	output logic                                         in_stall,
	input  wire logic [1:0]                              command,
	input  wire logic signed [tvmt_pkg::KEY_W-1:0]       key,
	input  wire logic signed [tvmt_pkg::VAL_W-1:0]       value,
	output logic                                         out_valid,
	input  wire logic                                    out_stall,
	output logic [1:0]                                   status,
	output logic [1:0]                                   found_count,
	output logic signed [tvmt_pkg::VAL_W-1:0]            first_value,
	output logic signed [tvmt_pkg::VAL_W-1:0]            second_value,
	output logic [tvmt_pkg::COUNT_OUT_W-1:0]             entry_count,
	output logic                                         table_empty,
	output logic                                         table_full
);

`include "two_value_multimap_table_defines.svh"

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	logic [tvmt_pkg::CAP_W-1:0]   cap_q;
	logic [31:0]                  cap_wide;
	logic [CNT_W-1:0]             cap_eff;

	logic                         ram_we;
	logic [IDX_W-1:0]             ram_waddr;
	logic [IDX_W-1:0]             ram_raddr;
	logic [tvmt_pkg::ENTRY_W-1:0] ram_wdata;
	logic [tvmt_pkg::ENTRY_W-1:0] ram_rdata;

	logic                         res_valid;
	logic                         res_free;
	tvmt_pkg::result_t            res;

	logic                         out_valid_q;
	tvmt_pkg::result_t            res_q;

	// Capacity register. A zero acts as one and anything above the table
	// depth acts as the depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= tvmt_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (cap_q == '0) begin
			cap_wide = 32'd1;
		end else if (32'(cap_q) > 32'(MAX_ENTRIES)) begin
			cap_wide = 32'(MAX_ENTRIES);
		end else begin
			cap_wide = 32'(cap_q);
		end
		cap_eff = cap_wide[CNT_W-1:0];
	end

	// One RAM holds each entry as key and value side by side.
	tvmt_ram #(
		.WIDTH (tvmt_pkg::ENTRY_W),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tvmt_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.key       (key),
		.value     (value),
		.cap_eff   (cap_eff),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res_free  (res_free),
		.res       (res)
	);

	// Output register: it separates the sequencer from the receiver, so a
	// stalled result does not keep the next request out.
	assign res_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_free) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign found_count  = res_q.found_count;
	assign first_value  = res_q.first_value;
	assign second_value = res_q.second_value;
	assign entry_count  = res_q.entry_count;
	assign table_empty  = res_q.table_empty;
	assign table_full   = res_q.table_full;

	// A finished result that cannot move on is held unchanged by the sequencer.
	`TVMT_ASSERT_NEXT(a_res_held, arst_n, res_valid && !res_free, res_valid && $stable(res), "result changed while waiting for the output register")
	// No request is taken while the sequencer presents a result.
	`TVMT_ASSERT_IMP(a_busy_when_result, arst_n, res_valid, in_stall, "request taken while a result is pending")
	// A full error comes only from a table at its capacity.
	`TVMT_ASSERT_IMP(a_full_flag, arst_n, res_valid && (res.status == tvmt_pkg::ST_FULL), res.table_full, "full error without full table")
	// A miss never reports found values.
	`TVMT_ASSERT_IMP(a_miss_none, arst_n, res_valid && (res.status == tvmt_pkg::ST_MISS), res.found_count == 2'd0, "miss reported with found values")

endmodule

`default_nettype wire
